// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the page bitmap engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PEBRE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pebre assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define PEBRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pebre assertion failed");

`endif

// ===== rtl/pebre_pkg.sv =====
// Package: constants, codes, payload and control types of the page bitmap engine.
package pebre_pkg;

  // Address space and page geometry
  localparam int ADDR_BITS  = 32;
  localparam int PAGE_BITS  = 12;
  localparam int FIELD_W    = 32;
  localparam int END_W      = 33;
  localparam int WIDE_W     = ((ADDR_BITS > 34) ? ADDR_BITS : 34) + 2;
  localparam int PAGE_IDX_W = ADDR_BITS - PAGE_BITS;
  localparam int PAGE_W     = PAGE_IDX_W + 1;

  // Bitmap storage: one row holds the bits of 2^LOG_ROW pages
  localparam int LOG_ROW   = 6;
  localparam int ROW_BITS  = 1 << LOG_ROW;
  localparam int ROW_IDX_W = PAGE_IDX_W - LOG_ROW;
  localparam int ROWS      = 1 << ROW_IDX_W;

  localparam logic [WIDE_W-1:0] SPACE_SIZE = WIDE_W'(1) << ADDR_BITS;
  localparam logic [WIDE_W-1:0] PAGE_MASK  = (WIDE_W'(1) << PAGE_BITS) - WIDE_W'(1);

  // Command codes
  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_REMAP = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISALIGN = 2'd1;
  localparam logic [1:0] STAT_OVERLAP  = 2'd2;
  localparam logic [1:0] STAT_SPACE    = 2'd3;

  // Query answers
  localparam logic [1:0] EXEC_CLEAR = 2'd0;
  localparam logic [1:0] EXEC_SET   = 2'd1;
  localparam logic [1:0] EXEC_MIXED = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FIELD_W-1:0] start_addr;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] new_start_addr;
    logic [FIELD_W-1:0] new_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         exec_state;
    logic               invalidate;
    logic [FIELD_W-1:0] inval_start;
    logic [END_W-1:0]   inval_end;
    logic               last;
  } out_item_t;

  // Page ranges the walker can be pointed at
  typedef enum logic [2:0] {
    R_S_L,    // old region
    R_S_ML,   // old start, shorter of both lengths
    R_NS_NL,  // new region
    R_NE_OE,  // shrunk tail
    R_OE_NE   // grown tail
  } rng_sel_t;

  // Invalidation ranges that can be recorded
  typedef enum logic [1:0] {
    I_S_OE,
    I_NS_NE,
    I_NE_OE,
    I_OE_NE
  } inv_sel_t;

  typedef enum logic [2:0] {
    C_IDLE, C_PREP, C_CHECK, C_RUN_A, C_RUN_B, C_RUN_C, C_SEND0, C_SEND1
  } ctrl_state_t;

  typedef enum logic [2:0] {
    W_CLEAR, W_IDLE, W_READ, W_MOD, W_DONE
  } walk_state_t;

  typedef struct packed {
    logic     start;
    logic     query;
    logic     val;
    rng_sel_t rng;
  } walk_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic any_set;
    logic any_clr;
    logic changed;
  } walk_stat_t;

  typedef struct packed {
    logic       latch;
    logic       prep;
    logic       set_stat;
    logic [1:0] stat_code;
    logic       set_exec;
    logic [1:0] exec_code;
    logic       rec_inv;
    inv_sel_t   inv_sel;
    logic       out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       misalign;
    logic       oos_old;
    logic       oos_new;
    logic       overlap;
    logic       same_start;
    logic       ne_le_oe;
    logic [1:0] n_inv;
  } dp_stat_t;

  // Page-aligned end of a byte range
  function automatic logic [WIDE_W-1:0] align_end(input logic [WIDE_W-1:0] a,
                                                  input logic [WIDE_W-1:0] b);
    logic [WIDE_W-1:0] sum;
    sum = a + b + PAGE_MASK;
    return sum & ~PAGE_MASK;
  endfunction

  // Page number of a byte address
  function automatic logic [PAGE_W-1:0] page_of(input logic [WIDE_W-1:0] a);
    logic [WIDE_W-1:0] sh;
    sh = a >> PAGE_BITS;
    return sh[PAGE_W-1:0];
  endfunction

endpackage

// ===== rtl/pebre_walker.sv =====
// Bitmap memory with a clearing pass after reset and a row-by-row range walker.
module pebre_walker
  import pebre_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  walk_cmd_t         wcmd,
  input  logic [PAGE_W-1:0] lo_page,
  input  logic [PAGE_W-1:0] hi_page,
  output walk_stat_t        wstat
);

  logic [ROW_BITS-1:0] mem [ROWS];

  walk_state_t          state_r, state_nxt;
  logic [PAGE_W-1:0]    cur_r, cur_nxt;
  logic [PAGE_W-1:0]    hi_r, hi_nxt;
  logic                 query_r, query_nxt;
  logic                 val_r, val_nxt;
  logic                 set_r, set_nxt;
  logic                 clr_r, clr_nxt;
  logic                 chg_r, chg_nxt;
  logic [ROW_IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [ROW_BITS-1:0]  rdata_r;

  logic [PAGE_W-1:0]    hi_adj;
  logic [PAGE_W-1:0]    next_cur;
  logic [ROW_BITS-1:0]  low_mask, high_mask, mask, new_row;
  logic                 same_row;
  logic [ROW_IDX_W-1:0] row_idx;
  logic                 we;
  logic [ROW_IDX_W-1:0] waddr;
  logic [ROW_BITS-1:0]  wdata;

  assign row_idx   = cur_r[PAGE_IDX_W-1:LOG_ROW];
  // a query always looks at its first page
  assign hi_adj = (wcmd.query && (hi_page <= lo_page)) ? lo_page + PAGE_W'(1) : hi_page;

  // Pages of the current row that lie in the range
  assign same_row  = hi_r[PAGE_W-1:LOG_ROW] == cur_r[PAGE_W-1:LOG_ROW];
  assign low_mask  = {ROW_BITS{1'b1}} << cur_r[LOG_ROW-1:0];
  assign high_mask = same_row ? ((ROW_BITS'(1) << hi_r[LOG_ROW-1:0]) - ROW_BITS'(1))
                              : {ROW_BITS{1'b1}};
  assign mask      = low_mask & high_mask;
  assign new_row   = val_r ? (rdata_r | mask) : (rdata_r & ~mask);
  assign next_cur  = {cur_r[PAGE_W-1:LOG_ROW] + 1'b1, LOG_ROW'(0)};

  // Walker sequencing
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    hi_nxt      = hi_r;
    query_nxt   = query_r;
    val_nxt     = val_r;
    set_nxt     = set_r;
    clr_nxt     = clr_r;
    chg_nxt     = chg_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      W_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == ROW_IDX_W'(ROWS - 1)) begin
          state_nxt = W_IDLE;
        end
      end
      W_IDLE, W_DONE: begin
        state_nxt = W_IDLE;
        if (wcmd.start) begin
          cur_nxt   = lo_page;
          hi_nxt    = hi_adj;
          query_nxt = wcmd.query;
          val_nxt   = wcmd.val;
          set_nxt   = 1'b0;
          clr_nxt   = 1'b0;
          chg_nxt   = 1'b0;
          state_nxt = (lo_page < hi_adj) ? W_READ : W_DONE;
        end
      end
      W_READ: begin
        state_nxt = W_MOD;
      end
      W_MOD: begin
        set_nxt   = set_r | (|(rdata_r & mask));
        clr_nxt   = clr_r | (|(~rdata_r & mask));
        chg_nxt   = chg_r | (|((rdata_r ^ {ROW_BITS{val_r}}) & mask));
        cur_nxt   = next_cur;
        state_nxt = (next_cur >= hi_r) ? W_DONE : W_READ;
      end
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= W_CLEAR;
      clr_idx_r <= '0;
      set_r     <= 1'b0;
      clr_r     <= 1'b0;
      chg_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      set_r     <= set_nxt;
      clr_r     <= clr_nxt;
      chg_r     <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    hi_r    <= hi_nxt;
    query_r <= query_nxt;
    val_r   <= val_nxt;
  end

  // Single write port; read data registered
  assign we    = (state_r == W_CLEAR) || ((state_r == W_MOD) && !query_r);
  assign waddr = (state_r == W_CLEAR) ? clr_idx_r : row_idx;
  assign wdata = (state_r == W_CLEAR) ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[row_idx];
  end

  assign wstat.ready   = state_r == W_IDLE;
  assign wstat.done    = state_r == W_DONE;
  assign wstat.any_set = set_r;
  assign wstat.any_clr = clr_r;
  assign wstat.changed = chg_r;

endmodule

// ===== rtl/pebre_dp.sv =====
// Datapath: command register, range arithmetic, checks and result registers.
module pebre_dp
  import pebre_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_item,
  input  dp_cmd_t           dcmd,
  input  rng_sel_t          rng,
  output dp_stat_t          dstat,
  output logic [PAGE_W-1:0] lo_page,
  output logic [PAGE_W-1:0] hi_page,
  output out_item_t         out_item
);

  in_item_t          in_r;
  logic [WIDE_W-1:0] oe_r, ne_r, qe_r, send_r, nsend_r;
  logic [1:0]        status_r, exec_r;
  logic [1:0]        n_inv_r;
  logic [FIELD_W-1:0] inv_s_r [2];
  logic [END_W-1:0]   inv_e_r [2];

  logic [WIDE_W-1:0]  s, l, ns, nl, mlen;
  logic [WIDE_W-1:0]  rec_s, rec_e;

  assign s    = WIDE_W'(in_r.start_addr);
  assign l    = WIDE_W'(in_r.length);
  assign ns   = WIDE_W'(in_r.new_start_addr);
  assign nl   = WIDE_W'(in_r.new_length);
  assign mlen = (l < nl) ? l : nl;

  // Range checks off the registered ends
  assign dstat.cmd        = in_r.cmd;
  assign dstat.misalign   = (|in_r.start_addr[PAGE_BITS-1:0]) ||
                            (|in_r.new_start_addr[PAGE_BITS-1:0]);
  assign dstat.oos_old    = (s >= SPACE_SIZE) || (oe_r > SPACE_SIZE);
  assign dstat.oos_new    = (ns >= SPACE_SIZE) || (ne_r > SPACE_SIZE);
  assign dstat.overlap    = !((send_r <= ns) || (nsend_r <= s));
  assign dstat.same_start = in_r.start_addr == in_r.new_start_addr;
  assign dstat.ne_le_oe   = ne_r <= oe_r;
  assign dstat.n_inv      = n_inv_r;

  // Page bounds for the walker
  always_comb begin
    lo_page = page_of(s);
    hi_page = page_of(oe_r);
    case (rng)
      R_S_L:   begin lo_page = page_of(s);    hi_page = page_of(oe_r); end
      R_S_ML:  begin lo_page = page_of(s);    hi_page = page_of(qe_r); end
      R_NS_NL: begin lo_page = page_of(ns);   hi_page = page_of(ne_r); end
      R_NE_OE: begin lo_page = page_of(ne_r); hi_page = page_of(oe_r); end
      R_OE_NE: begin lo_page = page_of(oe_r); hi_page = page_of(ne_r); end
      default: begin lo_page = page_of(s);    hi_page = page_of(oe_r); end
    endcase
  end

  // Invalidation range to record
  always_comb begin
    rec_s = s;
    rec_e = oe_r;
    case (dcmd.inv_sel)
      I_S_OE:  begin rec_s = s;    rec_e = oe_r; end
      I_NS_NE: begin rec_s = ns;   rec_e = ne_r; end
      I_NE_OE: begin rec_s = ne_r; rec_e = oe_r; end
      I_OE_NE: begin rec_s = oe_r; rec_e = ne_r; end
      default: begin rec_s = s;    rec_e = oe_r; end
    endcase
  end

  // Command payload and derived ends
  always_ff @(posedge clk) begin
    if (dcmd.latch) begin
      in_r <= in_item;
    end
    if (dcmd.prep) begin
      oe_r    <= align_end(s, l);
      ne_r    <= align_end(ns, nl);
      qe_r    <= align_end(s, mlen);
      send_r  <= s + l;
      nsend_r <= ns + nl;
    end
    if (dcmd.rec_inv) begin
      inv_s_r[n_inv_r[0]] <= rec_s[FIELD_W-1:0];
      inv_e_r[n_inv_r[0]] <= rec_e[END_W-1:0];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= STAT_OK;
      exec_r   <= EXEC_CLEAR;
      n_inv_r  <= 2'd0;
    end else if (dcmd.latch) begin
      status_r <= STAT_OK;
      exec_r   <= EXEC_CLEAR;
      n_inv_r  <= 2'd0;
    end else begin
      if (dcmd.set_stat) begin
        status_r <= dcmd.stat_code;
      end
      if (dcmd.set_exec) begin
        exec_r <= dcmd.exec_code;
      end
      if (dcmd.rec_inv) begin
        n_inv_r <= n_inv_r + 2'd1;
      end
    end
  end

  // Result transaction payload
  always_comb begin
    if (n_inv_r == 2'd0) begin
      out_item.status      = status_r;
      out_item.exec_state  = exec_r;
      out_item.invalidate  = 1'b0;
      out_item.inval_start = '0;
      out_item.inval_end   = '0;
      out_item.last        = 1'b1;
    end else begin
      out_item.status      = STAT_OK;
      out_item.exec_state  = EXEC_CLEAR;
      out_item.invalidate  = 1'b1;
      out_item.inval_start = inv_s_r[dcmd.out_idx];
      out_item.inval_end   = inv_e_r[dcmd.out_idx];
      out_item.last        = {1'b0, dcmd.out_idx} == (n_inv_r - 2'd1);
    end
  end

endmodule

// ===== rtl/pebre_ctrl.sv =====
// Controller: sequences checks, bitmap walks and result transactions per command.
module pebre_ctrl
  import pebre_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  walk_stat_t wstat,
  input  dp_stat_t   dstat,
  output walk_cmd_t  wcmd,
  output dp_cmd_t    dcmd
);

  ctrl_state_t state_r, state_nxt;
  logic        b_clear_r, b_clear_nxt;
  logic [1:0]  qcode;
  logic        set1;

  assign qcode = (wstat.any_set && wstat.any_clr) ? EXEC_MIXED :
                 wstat.any_set ? EXEC_SET : EXEC_CLEAR;
  assign set1  = qcode == EXEC_SET;

  always_comb begin
    state_nxt   = state_r;
    b_clear_nxt = b_clear_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    wcmd        = '{start: 1'b0, query: 1'b0, val: 1'b0, rng: R_S_L};
    dcmd        = '{latch: 1'b0, prep: 1'b0, set_stat: 1'b0, stat_code: STAT_OK,
                    set_exec: 1'b0, exec_code: EXEC_CLEAR, rec_inv: 1'b0,
                    inv_sel: I_S_OE, out_idx: 1'b0};
    unique case (state_r)
      C_IDLE: begin
        in_ready = wstat.ready;
        if (in_valid && wstat.ready) begin
          dcmd.latch = 1'b1;
          state_nxt  = C_PREP;
        end
      end
      C_PREP: begin
        dcmd.prep = 1'b1;
        state_nxt = C_CHECK;
      end
      // Reject or launch the first walk
      C_CHECK: begin
        state_nxt = C_RUN_A;
        if (dstat.cmd != CMD_REMAP) begin
          if (dstat.oos_old) begin
            dcmd.set_stat  = 1'b1;
            dcmd.stat_code = STAT_SPACE;
            state_nxt      = C_SEND0;
          end else begin
            wcmd.start = 1'b1;
            wcmd.query = dstat.cmd == CMD_QUERY;
            wcmd.val   = dstat.cmd == CMD_SET;
            wcmd.rng   = R_S_L;
          end
        end else if (dstat.misalign) begin
          dcmd.set_stat  = 1'b1;
          dcmd.stat_code = STAT_MISALIGN;
          state_nxt      = C_SEND0;
        end else if (dstat.oos_old || dstat.oos_new) begin
          dcmd.set_stat  = 1'b1;
          dcmd.stat_code = STAT_SPACE;
          state_nxt      = C_SEND0;
        end else if (dstat.same_start) begin
          wcmd.start = 1'b1;
          wcmd.query = !dstat.ne_le_oe;
          wcmd.rng   = dstat.ne_le_oe ? R_NE_OE : R_S_L;
        end else if (dstat.overlap) begin
          dcmd.set_stat  = 1'b1;
          dcmd.stat_code = STAT_OVERLAP;
          state_nxt      = C_SEND0;
        end else begin
          wcmd.start = 1'b1;
          wcmd.query = 1'b1;
          wcmd.rng   = R_S_ML;
        end
      end
      C_RUN_A: begin
        if (wstat.done) begin
          if (dstat.cmd != CMD_REMAP) begin
            dcmd.set_exec  = dstat.cmd == CMD_QUERY;
            dcmd.exec_code = qcode;
            dcmd.rec_inv   = (dstat.cmd == CMD_CLEAR) && wstat.changed;
            dcmd.inv_sel   = I_S_OE;
            state_nxt      = C_SEND0;
          end else if (dstat.same_start && dstat.ne_le_oe) begin
            dcmd.rec_inv = wstat.changed;
            dcmd.inv_sel = I_NE_OE;
            state_nxt    = C_SEND0;
          end else begin
            // copy the all-set state, else clear the new pages
            wcmd.start  = 1'b1;
            wcmd.val    = set1;
            wcmd.rng    = dstat.same_start ? R_OE_NE : R_NS_NL;
            b_clear_nxt = !set1;
            state_nxt   = C_RUN_B;
          end
        end
      end
      C_RUN_B: begin
        if (wstat.done) begin
          dcmd.rec_inv = b_clear_r && wstat.changed;
          dcmd.inv_sel = dstat.same_start ? I_OE_NE : I_NS_NE;
          if (dstat.same_start) begin
            state_nxt = C_SEND0;
          end else begin
            wcmd.start = 1'b1;
            wcmd.rng   = R_S_L;
            state_nxt  = C_RUN_C;
          end
        end
      end
      C_RUN_C: begin
        if (wstat.done) begin
          dcmd.rec_inv = wstat.changed;
          dcmd.inv_sel = I_S_OE;
          state_nxt    = C_SEND0;
        end
      end
      C_SEND0: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = (dstat.n_inv == 2'd2) ? C_SEND1 : C_IDLE;
        end
      end
      C_SEND1: begin
        out_valid    = 1'b1;
        dcmd.out_idx = 1'b1;
        if (out_ready) begin
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= C_IDLE;
      b_clear_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      b_clear_r <= b_clear_nxt;
    end
  end

endmodule

// ===== rtl/page_exec_bitmap_range_engine.sv =====
// Top level of the page executable-bitmap range engine.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_item  (in_item_t)
//   out     | output    | out_valid / out_ready | out_item (out_item_t)
//
// A command runs its checks, then walks the bitmap one 64-page row at a time, reading
// each row that a walk touches and, except in a query walk, writing it back (up to three
// walks for remap), then sends one or two result transactions.
// After reset a clearing pass writes all 2^(ADDR_BITS-PAGE_BITS-6) rows, one per
// cycle, with in_ready low.
// One command is in flight at a time; results wait in place while out_ready is low.
`include "assert_macros.svh"

module page_exec_bitmap_range_engine
  import pebre_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  walk_cmd_t         wcmd;
  walk_stat_t        wstat;
  dp_cmd_t           dcmd;
  dp_stat_t          dstat;
  logic [PAGE_W-1:0] lo_page, hi_page;

  pebre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .wstat     (wstat),
    .dstat     (dstat),
    .wcmd      (wcmd),
    .dcmd      (dcmd)
  );

  pebre_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .dcmd     (dcmd),
    .rng      (wcmd.rng),
    .dstat    (dstat),
    .lo_page  (lo_page),
    .hi_page  (hi_page),
    .out_item (out_item)
  );

  pebre_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .wcmd    (wcmd),
    .lo_page (lo_page),
    .hi_page (hi_page),
    .wstat   (wstat)
  );

  // A new command never lands while a result is still pending
  `PEBRE_ASSERT_NOW(a_no_accept_in_send, in_valid && in_ready, !out_valid)
  // A non-final result is always followed by another one
  `PEBRE_ASSERT_NEXT(a_second_follows, out_valid && out_ready && !out_item.last, out_valid)
  // Walks only finish while no result is offered
  `PEBRE_ASSERT_NOW(a_walk_not_in_send, wstat.done, !out_valid)

endmodule
